### rtl/assert_macros.svh
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

### rtl/ladrc_pkg.sv
// Package: types and constants of the ADRC controller.
package ladrc_pkg;
   localparam int CsrIdxW = 3;

   localparam logic [CsrIdxW-1:0] RegSampleTime = 3'd0;
   localparam logic [CsrIdxW-1:0] RegPlantGain  = 3'd1;
   localparam logic [CsrIdxW-1:0] RegGainL1     = 3'd2;
   localparam logic [CsrIdxW-1:0] RegGainL2     = 3'd3;
   localparam logic [CsrIdxW-1:0] RegGainL3     = 3'd4;
   localparam logic [CsrIdxW-1:0] RegGainKp     = 3'd5;
   localparam logic [CsrIdxW-1:0] RegGainKd     = 3'd6;

   typedef struct packed {
      logic signed [31:0] measurement;
      logic signed [31:0] applied_drive;
      logic signed [31:0] reference;
      logic               clear;
   } req_type;

   typedef struct packed {
      logic signed [31:0] drive;
      logic signed [31:0] est_position;
      logic signed [31:0] est_rate;
      logic signed [31:0] est_disturbance;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic [CsrIdxW-1:0] index;
      logic [31:0]        data;
   } csr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } state_type;
endpackage

### rtl/ladrc_if.sv
// Valid/ready channel interface with a typed payload.
interface ladrc_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### rtl/linear_adrc_controller.sv
// Top level: third-order linear ADRC with discrete current-form ESO.
// One sample item runs through 14 sequencer steps around one shared 33x33
// multiplier (13 registered products, one per cycle), then the divide state
// (start, a restoring divider for the control law division by plant_gain,
// then capture) and the output state, which loads the result register. With
// zero plant_gain or an out-of-range numerator the divider is skipped and the
// divide state goes straight to the output state. A clear item skips the
// multiplier and divider and goes straight to the output state. A result
// waiting on rsp_ready holds the following result in the output state, which
// delays its loading and the acceptance of the next item. The block takes one
// item at a time; req_ready is high only when idle. All values are signed
// fixed point with FRAC_BITS fraction bits, but for the sample time and its
// half square Th, which are unsigned with 32 fraction bits; every stored or
// output value saturates to 32 bits and raises the saturated flag.
// Configuration writes are always ready and should only be issued while
// idle.
module linear_adrc_controller #(
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   ladrc_if.sink   req,
   ladrc_if.source rsp,
   ladrc_if.sink   csr
);
   localparam logic signed [65:0] Max32 = 66'sd2147483647;
   localparam logic signed [65:0] Min32 = -66'sd2147483648;
   localparam logic signed [65:0] Lim = (66'sd1 <<< (62 - FRAC_BITS)) - 66'sd1;

   // Configuration registers
   logic        [31:0] tsamp_ff;
   logic signed [31:0] b0_ff, l1_ff, l2_ff, l3_ff, kp_ff, kd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tsamp_ff <= 32'd4294967;
         b0_ff    <= 32'sd1 <<< FRAC_BITS;
         l1_ff    <= '0;
         l2_ff    <= '0;
         l3_ff    <= '0;
         kp_ff    <= '0;
         kd_ff    <= '0;
      end else if (csr.valid && csr.ready) begin
         case (csr.data.index)
            ladrc_pkg::RegSampleTime: tsamp_ff <= csr.data.data;
            ladrc_pkg::RegPlantGain:  b0_ff    <= csr.data.data;
            ladrc_pkg::RegGainL1:     l1_ff    <= csr.data.data;
            ladrc_pkg::RegGainL2:     l2_ff    <= csr.data.data;
            ladrc_pkg::RegGainL3:     l3_ff    <= csr.data.data;
            ladrc_pkg::RegGainKp:     kp_ff    <= csr.data.data;
            ladrc_pkg::RegGainKd:     kd_ff    <= csr.data.data;
            default: ;
         endcase
      end
   end
   assign csr.ready = 1'b1;

   // Sequencer state
   ladrc_pkg::state_type state_ff, state_in;
   logic [3:0]  step_ff, step_in;
   logic signed [31:0] x1_ff, x1_in, x2_ff, x2_in, x3_ff, x3_in;
   logic signed [31:0] y_ff, y_in, ua_ff, ua_in, ref_ff, ref_in;
   logic        [31:0] th_ff, th_in;
   logic signed [31:0] bt_ff, bt_in, bth_ff, bth_in, p1_ff, p1_in;
   logic signed [65:0] acc_ff, acc_in;   // running sum
   logic signed [32:0] e_ff, e_in;
   logic               flag_ff, flag_in;
   ladrc_pkg::rsp_type res_ff, res_in;   // result being built
   ladrc_pkg::rsp_type out_ff, out_in;
   logic               ovld_ff, ovld_in;
   logic               div_start;

   // Shared multiplier, one registered product per step
   logic signed [32:0] ma, mb;
   logic               mshift;
   logic signed [65:0] prod_ff;
   logic signed [65:0] mprod;

   assign mprod = ma * mb;
   always_ff @(posedge clock) begin
      prod_ff <= mshift ? (mprod >>> 32) : (mprod >>> FRAC_BITS);
   end

   logic signed [65:0] prod;
   assign prod = prod_ff;

   // Divider for the control law
   logic               div_done;
   logic signed [63:0] div_q;
   logic signed [63:0] div_num;
   assign div_num = 64'(acc_ff) <<< FRAC_BITS;

   ladrc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (b0_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   function automatic logic signed [31:0] sat(input logic signed [65:0] v,
                                              inout logic f);
      if (v > Max32) begin
         f = 1'b1;
         return 32'sh7fffffff;
      end
      if (v < Min32) begin
         f = 1'b1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // Step schedule: the operand pair of step k is issued by step k and its
   // registered product (prod_ff) is used by step k+1.
   //  0: T*T (>>32, then >>1 -> Th)      1: b0*T -> bT
   //  2: b0*Th -> bTh                   3: x2*T
   //  4: x3*Th                           5: bTh*ua (Q)
   //  6: x3*T                            7: bT*ua (Q) -> p0,e  8: l1*e
   //  9: l2*e                            10: l3*e             11: kp*(ref-x1)
   //  12: kd*x2                          13: num ready
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      x1_in = x1_ff; x2_in = x2_ff; x3_in = x3_ff;
      y_in = y_ff; ua_in = ua_ff; ref_in = ref_ff;
      th_in = th_ff; bt_in = bt_ff; bth_in = bth_ff; p1_in = p1_ff;
      acc_in = acc_ff; e_in = e_ff; flag_in = flag_ff;
      res_in = res_ff;
      out_in = out_ff; ovld_in = ovld_ff;
      div_start = 1'b0;
      ma = '0; mb = '0; mshift = 1'b1;
      if (ovld_ff && rsp.ready) ovld_in = 1'b0;
      case (state_ff)
         ladrc_pkg::ST_IDLE: begin
            if (req.valid) begin
               y_in = req.data.measurement;
               ua_in = req.data.applied_drive;
               ref_in = req.data.reference;
               flag_in = 1'b0;
               step_in = '0;
               if (req.data.clear) begin
                  x1_in = '0; x2_in = '0; x3_in = '0;
                  res_in = '0;
                  state_in = ladrc_pkg::ST_OUT;
               end else begin
                  state_in = ladrc_pkg::ST_MUL;
               end
            end
         end
         ladrc_pkg::ST_MUL: begin
            step_in = step_ff + 4'd1;
            case (step_ff)
               4'd0: begin ma = {1'b0, tsamp_ff}; mb = {1'b0, tsamp_ff}; end
               4'd1: begin
                  th_in = prod[32:1];
                  ma = 33'(b0_ff); mb = {1'b0, tsamp_ff};
               end
               4'd2: begin
                  bt_in = sat(prod, flag_in);
                  ma = 33'(b0_ff); mb = {1'b0, th_ff};
               end
               4'd3: begin
                  bth_in = sat(prod, flag_in);
                  acc_in = 66'(x1_ff);
                  ma = 33'(x2_ff); mb = {1'b0, tsamp_ff};
               end
               4'd4: begin
                  acc_in = acc_ff + prod;
                  ma = 33'(x3_ff); mb = {1'b0, th_ff};
               end
               4'd5: begin
                  acc_in = acc_ff + prod;
                  ma = 33'(bth_ff); mb = 33'(ua_ff); mshift = 1'b0;
               end
               4'd6: begin
                  acc_in = acc_ff + prod;  // p0 sum complete
                  ma = 33'(x3_ff); mb = {1'b0, tsamp_ff};
               end
               4'd7: begin
                  // saturate p0, form innovation; start p1 sum
                  x1_in = sat(acc_ff, flag_in);
                  e_in = 33'(y_ff) - 33'(x1_in);
                  acc_in = 66'(x2_ff) + prod;
                  ma = 33'(bt_ff); mb = 33'(ua_ff); mshift = 1'b0;
               end
               4'd8: begin
                  p1_in = sat(acc_ff + prod, flag_in);
                  ma = 33'(l1_ff); mb = e_ff; mshift = 1'b0;
               end
               4'd9: begin
                  x1_in = sat(66'(x1_ff) + prod, flag_in);
                  ma = 33'(l2_ff); mb = e_ff; mshift = 1'b0;
               end
               4'd10: begin
                  x2_in = sat(66'(p1_ff) + prod, flag_in);
                  ma = 33'(l3_ff); mb = e_ff; mshift = 1'b0;
               end
               4'd11: begin
                  x3_in = sat(66'(x3_ff) + prod, flag_in);
                  ma = 33'(kp_ff); mb = 33'(ref_ff) - 33'(x1_ff); mshift = 1'b0;
               end
               4'd12: begin
                  acc_in = prod - 66'(x3_ff);
                  ma = 33'(kd_ff); mb = 33'(x2_ff); mshift = 1'b0;
               end
               default: begin
                  acc_in = acc_ff - prod;   // numerator
                  res_in.est_position = x1_ff;
                  res_in.est_rate = x2_ff;
                  res_in.est_disturbance = x3_ff;
                  state_in = ladrc_pkg::ST_DIV;
                  step_in = '0;
               end
            endcase
         end
         ladrc_pkg::ST_DIV: begin
            if (b0_ff == '0) begin
               flag_in = 1'b1;
               res_in.drive = (acc_ff > 0) ? 32'sh7fffffff :
                              (acc_ff < 0) ? 32'sh80000000 : 32'sd0;
               res_in.saturated = 1'b1;
               state_in = ladrc_pkg::ST_OUT;
            end else if (acc_ff > Lim || acc_ff < -Lim) begin
               res_in.drive = ((acc_ff > 0) == (b0_ff > 0)) ? 32'sh7fffffff
                                                             : 32'sh80000000;
               res_in.saturated = 1'b1;
               state_in = ladrc_pkg::ST_OUT;
            end else if (step_ff == '0) begin
               div_start = 1'b1;
               step_in = 4'd1;
            end else if (div_done) begin
               res_in.drive = sat(66'(div_q), flag_in);
               res_in.saturated = flag_in;
               state_in = ladrc_pkg::ST_OUT;
            end
         end
         ladrc_pkg::ST_OUT: begin
            // load the result register once the previous result has left
            if (!ovld_ff || rsp.ready) begin
               out_in = res_ff;
               ovld_in = 1'b1;
               state_in = ladrc_pkg::ST_IDLE;
            end
         end
         default: state_in = ladrc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ladrc_pkg::ST_IDLE;
         step_ff  <= '0;
         ovld_ff  <= 1'b0;
         x1_ff <= '0; x2_ff <= '0; x3_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         ovld_ff  <= ovld_in;
         x1_ff <= x1_in; x2_ff <= x2_in; x3_ff <= x3_in;
      end
      y_ff <= y_in; ua_ff <= ua_in; ref_ff <= ref_in;
      th_ff <= th_in; bt_ff <= bt_in; bth_ff <= bth_in; p1_ff <= p1_in;
      acc_ff <= acc_in; e_ff <= e_in; flag_ff <= flag_in;
      res_ff <= res_in;
      out_ff <= out_in;
   end

   // Result register; holds across output stalls.
   assign req.ready = (state_ff == ladrc_pkg::ST_IDLE);
   assign rsp.valid = ovld_ff;
   assign rsp.data  = out_ff;
endmodule

### rtl/ladrc_div.sv
// Restoring divider: signed quotient truncated toward zero, one bit per cycle.
module ladrc_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] dividend,
   input  logic signed [31:0] divisor,
   output logic               done,
   output logic signed [63:0] quotient
);
   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic [63:0] shifted;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[62:0], quo_ff[63]};
      trial   = {1'b0, shifted} - {33'd0, dvs_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend[63] ? 64'(-dividend) : 64'(dividend);
         dvs_in  = divisor[31] ? 32'(-divisor) : 32'(divisor);
         neg_in  = dividend[63] ^ divisor[31];
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[62:0], ~trial[64]};
         rem_in = trial[64] ? shifted : trial[63:0];
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? 64'(-quo_ff) : quo_ff;
endmodule

### rtl/ladrc_checker.sv
// Port-level checker for the ADRC controller, bound to the top level.
`include "assert_macros.svh"
module ladrc_checker (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input ladrc_pkg::rsp_type rsp_data
);
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "accepted a second item while busy")
   `ASSERT_IMPL(a_rsp_known, clock, reset, rsp_valid, !$isunknown(rsp_data), "result has unknown bits")
endmodule

bind linear_adrc_controller ladrc_checker u_ladrc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_data  (rsp.data)
);
